// ===== rtl/mvlp_pkg.sv =====
// ----------------------------------------------------------------------------
// mvlp_pkg
// Shared sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mvlp_pkg;

  localparam int MAX_NODES  = 4096;
  localparam int NODE_AW    = $clog2(MAX_NODES);
  localparam int MAX_MIXED  = 1024;
  localparam int MIX_AW     = $clog2(MAX_MIXED);
  localparam int CNT_W      = MIX_AW + 1;
  localparam int LABEL_BITS = 16;
  localparam int CORNER_W   = 13;
  localparam int NC_W       = 13;
  localparam int KMAX_W     = 3;
  localparam int ROW_W      = 8 * CORNER_W + KMAX_W;

  typedef enum logic [1:0] {
    KIND_TET   = 2'd0,
    KIND_MIX   = 2'd1,
    KIND_RUN   = 2'd2,
    KIND_QUERY = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAP,
    OP_CLR,
    OP_TET,
    OP_MIX,
    OP_PASS,
    OP_ROW,
    OP_ACC,
    OP_LWR,
    OP_NEXT,
    OP_PEND,
    OP_SRD,
    OP_SCHK,
    OP_QROW,
    OP_QACC,
    OP_LOAD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  run_ok;
    logic  q_ok;
    logic  q_last;
    logic  k_last;
    logic  best_nz;
    logic  elem_last;
    logic  clr_last;
    logic  scan_zero;
    logic  scan_last;
    logic  more_passes;
    logic  out_free;
  } sts_t;

endpackage

// ===== rtl/mvlp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mvlp_ctrl
// Sequencer: loads, propagation passes, node scan, query and label clear.
// ----------------------------------------------------------------------------
module mvlp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mvlp_pkg::sts_t  sts,
  output mvlp_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_TET, S_MIX, S_RUN, S_ROW, S_LRD, S_ACC,
    S_BEST, S_LWR, S_NEXT, S_SRD, S_SCHK, S_QROW, S_QRD, S_QACC, S_RESP
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = mvlp_pkg::OP_NONE;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = mvlp_pkg::OP_CLR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = mvlp_pkg::OP_CAP;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.kind)
          mvlp_pkg::KIND_TET: state_nxt = S_TET;
          mvlp_pkg::KIND_MIX: state_nxt = S_MIX;
          mvlp_pkg::KIND_RUN: state_nxt = S_RUN;
          default:            state_nxt = S_QROW;
        endcase
      end
      S_TET: begin
        cmd.op = mvlp_pkg::OP_TET;
        if (sts.k_last) state_nxt = S_RESP;
      end
      S_MIX: begin
        cmd.op    = mvlp_pkg::OP_MIX;
        state_nxt = S_RESP;
      end
      S_RUN: begin
        if (sts.run_ok) begin
          cmd.op    = mvlp_pkg::OP_PASS;
          state_nxt = S_ROW;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_ROW: begin
        cmd.op    = mvlp_pkg::OP_ROW;
        state_nxt = S_LRD;
      end
      S_LRD: state_nxt = S_ACC;
      S_ACC: begin
        cmd.op    = mvlp_pkg::OP_ACC;
        state_nxt = sts.k_last ? S_BEST : S_LRD;
      end
      S_BEST: state_nxt = sts.best_nz ? S_LWR : S_NEXT;
      S_LWR: begin
        cmd.op = mvlp_pkg::OP_LWR;
        if (sts.k_last) state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (sts.elem_last) begin
          cmd.op    = mvlp_pkg::OP_PEND;
          state_nxt = S_SRD;
        end else begin
          cmd.op    = mvlp_pkg::OP_NEXT;
          state_nxt = S_ROW;
        end
      end
      S_SRD: begin
        cmd.op    = mvlp_pkg::OP_SRD;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        cmd.op = mvlp_pkg::OP_SCHK;
        if (sts.scan_zero) state_nxt = sts.more_passes ? S_RUN : S_RESP;
        else if (sts.scan_last) state_nxt = S_RESP;
        else state_nxt = S_SRD;
      end
      S_QROW: begin
        if (sts.q_ok) begin
          cmd.op    = mvlp_pkg::OP_QROW;
          state_nxt = S_QRD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      // Keep the queried element row in the read register for the corner check
      S_QRD: begin
        cmd.op    = mvlp_pkg::OP_QROW;
        state_nxt = S_QACC;
      end
      S_QACC: begin
        cmd.op    = mvlp_pkg::OP_QACC;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.op = mvlp_pkg::OP_LOAD;
          if (sts.kind == mvlp_pkg::KIND_QUERY && sts.q_ok && sts.q_last)
            state_nxt = S_CLEAR;
          else
            state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

// ===== rtl/mvlp_dpath.sv =====
// ----------------------------------------------------------------------------
// mvlp_dpath
// Node label and element memories, counters, accumulators and result register.
// ----------------------------------------------------------------------------
module mvlp_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mvlp_pkg::cmd_t                      cmd,
  output mvlp_pkg::sts_t                      sts,
  input  logic [mvlp_pkg::NC_W-1:0]           node_count,
  input  logic [1:0]                          in_kind,
  input  logic [15:0]                         in_volume_id,
  input  logic [3:0]                          in_corner_count,
  input  logic [8*mvlp_pkg::CORNER_W-1:0]     in_corners,
  input  logic [9:0]                          in_mixed_index,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [15:0]                         out_label_out,
  output logic                                out_assigned,
  output logic [9:0]                          out_passes_done,
  output logic                                out_all_labeled
);

  localparam int CW = mvlp_pkg::CORNER_W;
  localparam int LB = mvlp_pkg::LABEL_BITS;
  localparam int NA = mvlp_pkg::NODE_AW;
  localparam int MA = mvlp_pkg::MIX_AW;
  localparam int KW = mvlp_pkg::KMAX_W;

  logic [LB-1:0]              node_mem [mvlp_pkg::MAX_NODES];
  logic [mvlp_pkg::ROW_W-1:0] row_mem  [mvlp_pkg::MAX_MIXED];

  mvlp_pkg::kind_t            kind_r;
  logic [LB-1:0]              vol_r;
  logic [KW-1:0]              kmax_r;
  logic [8*CW-1:0]            corners_r;
  logic [MA-1:0]              idx_r;
  logic                       tets_r;
  logic [mvlp_pkg::CNT_W-1:0] mixed_r;
  logic [MA-1:0]              elem_r;
  logic [KW-1:0]              k_r;
  logic [LB-1:0]              best_r;
  logic [MA-1:0]              passes_r;
  logic [NA-1:0]              s_r;
  logic [NA-1:0]              clr_r;
  logic [LB-1:0]              res_label_r;
  logic                       res_assigned_r;
  logic                       res_full_r;
  logic [LB-1:0]              node_q_r;
  logic [mvlp_pkg::ROW_W-1:0] row_q_r;
  logic                       out_valid_r;
  logic [15:0]                out_label_r;
  logic                       out_assigned_r;
  logic [9:0]                 out_passes_r;
  logic                       out_full_r;

  logic [KW-1:0]   in_kmax;
  logic [KW-1:0]   row_kmax;
  logic [CW-1:0]   cur_c;
  logic            cur_ok;
  logic [NA-1:0]   cur_addr;
  logic [LB-1:0]   cur_lbl;
  logic [NA-1:0]   n_raddr;
  logic            n_we;
  logic [NA-1:0]   n_waddr;
  logic [LB-1:0]   n_wdata;
  logic [MA-1:0]   r_raddr;
  logic [NA-1:0]   nscan_m1;
  logic            k_last;

  // Decode corner count to last corner position
  always_comb begin
    if (in_corner_count <= 4'd5)      in_kmax = KW'(4);
    else if (in_corner_count == 4'd6) in_kmax = KW'(5);
    else                              in_kmax = KW'(7);
  end

  assign row_kmax = row_q_r[mvlp_pkg::ROW_W-1 -: KW];
  assign k_last   = (kind_r == mvlp_pkg::KIND_TET) ? (k_r == KW'(3)) : (k_r == row_kmax);

  // Select current corner
  assign cur_c    = (kind_r == mvlp_pkg::KIND_TET) ? corners_r[k_r*CW +: CW]
                                                   : row_q_r[k_r*CW +: CW];
  assign cur_ok   = (cur_c != '0) && (cur_c <= CW'(mvlp_pkg::MAX_NODES));
  assign cur_addr = NA'(cur_c - CW'(1));
  assign cur_lbl  = cur_ok ? node_q_r : '0;

  // Clamp scanned node count
  always_comb begin
    if (node_count == '0)
      nscan_m1 = '0;
    else if (node_count > mvlp_pkg::NC_W'(mvlp_pkg::MAX_NODES))
      nscan_m1 = '1;
    else
      nscan_m1 = NA'(node_count - 1'b1);
  end

  // Node memory port selection
  assign n_raddr = (cmd.op == mvlp_pkg::OP_SRD) ? s_r : cur_addr;
  assign n_we    = (cmd.op == mvlp_pkg::OP_CLR) ||
                   ((cmd.op == mvlp_pkg::OP_TET || cmd.op == mvlp_pkg::OP_LWR) && cur_ok);
  assign n_waddr = (cmd.op == mvlp_pkg::OP_CLR) ? clr_r : cur_addr;
  always_comb begin
    if (cmd.op == mvlp_pkg::OP_CLR)      n_wdata = '0;
    else if (cmd.op == mvlp_pkg::OP_TET) n_wdata = vol_r;
    else                                 n_wdata = best_r;
  end

  always_ff @(posedge clk) begin
    if (n_we) node_mem[n_waddr] <= n_wdata;
    node_q_r <= node_mem[n_raddr];
  end

  // Element memory
  assign r_raddr = (cmd.op == mvlp_pkg::OP_QROW) ? idx_r : elem_r;

  always_ff @(posedge clk) begin
    if (cmd.op == mvlp_pkg::OP_MIX && mixed_r < mvlp_pkg::CNT_W'(mvlp_pkg::MAX_MIXED))
      row_mem[mixed_r[MA-1:0]] <= {kmax_r, corners_r};
    row_q_r <= row_mem[r_raddr];
  end

  // Capture item and step counters
  always_ff @(posedge clk) begin
    if (cmd.op == mvlp_pkg::OP_CAP) begin
      kind_r    <= mvlp_pkg::kind_t'(in_kind);
      vol_r     <= LB'(in_volume_id);
      kmax_r    <= in_kmax;
      corners_r <= in_corners;
      idx_r     <= in_mixed_index;
    end
    unique case (cmd.op)
      mvlp_pkg::OP_CAP: begin
        k_r            <= '0;
        passes_r       <= '0;
        res_label_r    <= '0;
        res_assigned_r <= 1'b0;
        res_full_r     <= 1'b0;
      end
      mvlp_pkg::OP_TET:  k_r <= k_r + 1'b1;
      mvlp_pkg::OP_PASS: elem_r <= '0;
      mvlp_pkg::OP_ROW: begin
        k_r    <= '0;
        best_r <= '0;
      end
      mvlp_pkg::OP_ACC: begin
        if (cur_lbl > best_r) best_r <= cur_lbl;
        k_r <= k_last ? '0 : k_r + 1'b1;
      end
      mvlp_pkg::OP_LWR:  k_r <= k_r + 1'b1;
      mvlp_pkg::OP_NEXT: elem_r <= elem_r + 1'b1;
      mvlp_pkg::OP_PEND: begin
        passes_r <= passes_r + 1'b1;
        s_r      <= '0;
      end
      mvlp_pkg::OP_SCHK: begin
        s_r        <= s_r + 1'b1;
        res_full_r <= (node_q_r != '0) && (s_r == nscan_m1);
      end
      mvlp_pkg::OP_QACC: begin
        res_label_r    <= cur_lbl;
        res_assigned_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // Control counters with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tets_r  <= 1'b0;
      mixed_r <= '0;
      clr_r   <= '0;
    end else begin
      if (cmd.op == mvlp_pkg::OP_TET) tets_r <= 1'b1;
      if (cmd.op == mvlp_pkg::OP_MIX && mixed_r < mvlp_pkg::CNT_W'(mvlp_pkg::MAX_MIXED))
        mixed_r <= mixed_r + 1'b1;
      if (cmd.op == mvlp_pkg::OP_CLR) clr_r <= clr_r + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.op == mvlp_pkg::OP_LOAD) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
    if (cmd.op == mvlp_pkg::OP_LOAD) begin
      out_label_r    <= 16'(res_label_r);
      out_assigned_r <= res_assigned_r;
      out_passes_r   <= 10'(passes_r);
      out_full_r     <= res_full_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_label_out   = out_label_r;
  assign out_assigned    = out_assigned_r;
  assign out_passes_done = out_passes_r;
  assign out_all_labeled = out_full_r;

  // Status to controller
  assign sts.kind        = kind_r;
  assign sts.run_ok      = tets_r && (mixed_r != '0);
  assign sts.q_ok        = tets_r && ({1'b0, idx_r} < mixed_r);
  assign sts.q_last      = ({1'b0, idx_r} + 1'b1) == mixed_r;
  assign sts.k_last      = k_last;
  assign sts.best_nz     = (best_r != '0);
  assign sts.elem_last   = ({1'b0, elem_r} + 1'b1) == mixed_r;
  assign sts.clr_last    = &clr_r;
  assign sts.scan_zero   = (node_q_r == '0);
  assign sts.scan_last   = (s_r == nscan_m1);
  assign sts.more_passes = ({1'b0, passes_r} + 1'b1) < mixed_r;
  assign sts.out_free    = !out_valid_r || !out_stall;

endmodule

// ===== rtl/mesh_volume_label_propagation.sv =====
// ----------------------------------------------------------------------------
// mesh_volume_label_propagation
// Tetrahedron label loading and label propagation over mixed elements.
// ----------------------------------------------------------------------------
// A run repeats passes; each pass visits every mixed element, reading each corner label and, if the
//   largest is nonzero, writing it to every valid corner, then scans nodes up to the first unlabelled one.
// One item in flight at a time, the next taken the cycle after its result loads unless a clear
//   sweep follows; a waiting result does not block the next item.
// Reset (and a query of the last element) sweeps the 4096-entry node memory.
module mesh_volume_label_propagation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_volume_id,
  input  logic [3:0]  in_corner_count,
  input  logic [12:0] in_corner_a,
  input  logic [12:0] in_corner_b,
  input  logic [12:0] in_corner_c,
  input  logic [12:0] in_corner_d,
  input  logic [12:0] in_corner_e,
  input  logic [12:0] in_corner_f,
  input  logic [12:0] in_corner_g,
  input  logic [12:0] in_corner_h,
  input  logic [9:0]  in_mixed_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_label_out,
  output logic        out_assigned,
  output logic [9:0]  out_passes_done,
  output logic        out_all_labeled,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mvlp_pkg::cmd_t cmd;
  mvlp_pkg::sts_t sts;
  logic [mvlp_pkg::NC_W-1:0] node_count_r;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) node_count_r <= mvlp_pkg::NC_W'(mvlp_pkg::MAX_NODES);
    else if (psel && penable && pwrite && !paddr[2])
      node_count_r <= pwdata[mvlp_pkg::NC_W-1:0];
  end
  assign prdata = paddr[2] ? 32'd0 : {{(32-mvlp_pkg::NC_W){1'b0}}, node_count_r};

  mvlp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mvlp_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .node_count      (node_count_r),
    .in_kind         (in_kind),
    .in_volume_id    (in_volume_id),
    .in_corner_count (in_corner_count),
    .in_corners      ({in_corner_h, in_corner_g, in_corner_f, in_corner_e,
                       in_corner_d, in_corner_c, in_corner_b, in_corner_a}),
    .in_mixed_index  (in_mixed_index),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_label_out   (out_label_out),
    .out_assigned    (out_assigned),
    .out_passes_done (out_passes_done),
    .out_all_labeled (out_all_labeled)
  );

  // An accepted transaction always blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  // A run result never carries a query label
  a_run_no_label: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_passes_done != '0) |-> (!out_assigned && out_label_out == '0))
    else $error("run result carries query fields");

  // Fully labelled needs at least one pass
  a_full_needs_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_all_labeled) |-> (out_passes_done != '0))
    else $error("all_labeled without a pass");

endmodule
